@@ rtl/pfl_pkg.sv @@
// pfl_pkg: shared types and constants for the pool free-list allocator
// used by pool_free_list_allocator and pfl_checker
// no dependencies
package pfl_pkg;

  // pool geometry
  localparam int NUM_BLOCKS  = 256;
  localparam int INDEX_SPACE = 256;
  localparam int CAP_LIMIT   = (NUM_BLOCKS < INDEX_SPACE) ? NUM_BLOCKS : INDEX_SPACE;
  localparam int INDEX_W     = $clog2(INDEX_SPACE);
  localparam int COUNT_W     = 9;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(CAP_LIMIT);

  // register reset values
  localparam logic [31:0]        BASE_RESET  = 32'd0;
  localparam logic [15:0]        SIZE_RESET  = 16'd64;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

  // register map, index is paddr[3:2]
  localparam logic [1:0] REG_BASE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_BLOCK_SIZE   = 2'd1;
  localparam logic [1:0] REG_BLOCK_COUNT  = 2'd2;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_RESET = 2'd2,
    REQ_NOP   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_OVERSIZE = 2'd2,
    STAT_RANGE    = 2'd3
  } status_t;

endpackage

@@ rtl/pool_free_list_allocator.sv @@
// pool_free_list_allocator: fixed-size block pool with a free list and lazy bump pointer
// depends on pfl_pkg and pfl_ram
// configuration through an apb-style port, requests and results as streams
//
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   tuser: req_type; tdata: request_size, free_index
// m_*       out  m_tvalid/m_tready   tuser: status; tdata: index, address, free_count
// apb       in   psel/penable        base_address, blk_bytes, block_count
//
// one item per cycle while results are taken: each request is settled in the cycle
// it is accepted and its result lands in the output register on the same edge
// the link ram is read at the next head address, so the link of the head is always
// ready; a free forwards its new link while the ram read still returns the old contents
// synchronous reset clears the head, the link valid bits and the output valid bit, no
// clearing pass is needed; a stalled result holds s_tready low until it is taken
module pool_free_list_allocator
  import pfl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [15:0] request_size, [23:16] free_index
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [7:0] block_index, [39:8] block_address,
                                 // [48:40] free_count, [55:49] zero
  output logic [1:0]  m_tuser,   // [1:0] status
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [31:0]        base_address;
  logic [15:0]        blk_bytes;
  logic [COUNT_W-1:0] block_count;

  // pool state
  logic [COUNT_W-1:0]     head_index, head_index_next;
  logic [COUNT_W-1:0]     free_blocks, free_blocks_next;
  logic [INDEX_SPACE-1:0] link_valid;

  // forwarding of a link written by the previous free
  logic               fwd_valid;
  logic [INDEX_W-1:0] fwd_link;

  // output register
  logic               out_valid;
  status_t            out_status;
  logic [INDEX_W-1:0] out_index;
  logic [31:0]        out_address;
  logic [COUNT_W-1:0] out_count;

  // request decode
  req_type_t          req;
  logic [15:0]        req_size;
  logic [INDEX_W-1:0] req_fidx;
  logic               s_fire;
  logic               cfg_write;

  // per-request combinational results
  status_t            res_status;
  logic [INDEX_W-1:0] res_index;
  logic [31:0]        res_address;
  logic               link_we;
  logic               pool_clear;
  logic               free_ok;

  logic [COUNT_W-1:0] count_eff;
  logic [INDEX_W-1:0] head_low;
  logic [INDEX_W-1:0] ram_rdata;
  logic [INDEX_W-1:0] head_link;
  logic               head_valid;
  logic [23:0]        offset;

  assign req      = req_type_t'(s_tuser);
  assign req_size = s_tdata[15:0];
  assign req_fidx = s_tdata[23:16];

  assign s_tready = !out_valid || m_tready;
  assign s_fire   = s_tvalid && s_tready;

  // ---------------------------------------------------------------- config port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= BASE_RESET;
      blk_bytes    <= SIZE_RESET;
      block_count  <= COUNT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_BASE_ADDRESS: base_address <= pwdata;
        REG_BLOCK_SIZE:   blk_bytes    <= pwdata[15:0];
        REG_BLOCK_COUNT:  block_count  <= pwdata[COUNT_W-1:0];
        default: ;  // unmapped, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BASE_ADDRESS: prdata = base_address;
      REG_BLOCK_SIZE:   prdata = {16'd0, blk_bytes};
      REG_BLOCK_COUNT:  prdata = {{(32-COUNT_W){1'b0}}, block_count};
      default:          prdata = '0;
    endcase
  end

  // block count is capped at the index space
  assign count_eff = (block_count > COUNT_CAP) ? COUNT_CAP : block_count;

  // ---------------------------------------------------------------- link store
  // read address is the head of the next cycle, so ram_rdata always belongs to
  // the current head; the one exception is the cycle after a free, when the
  // head's link was written on the same edge and comes from fwd_link instead
  pfl_ram #(
    .WIDTH (INDEX_W),
    .DEPTH (INDEX_SPACE)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (req_fidx),
    .wdata (head_low),
    .raddr (head_index_next[INDEX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign head_low   = head_index[INDEX_W-1:0];
  assign head_link  = fwd_valid ? fwd_link : ram_rdata;
  assign head_valid = link_valid[head_low];
  assign offset     = 24'(head_low) * 24'(blk_bytes);

  // ---------------------------------------------------------------- request logic
  always_comb begin
    head_index_next  = head_index;
    free_blocks_next = free_blocks;
    res_status       = STAT_OK;
    res_index        = '0;
    res_address      = '0;
    link_we          = 1'b0;
    pool_clear       = 1'b0;
    free_ok          = 1'b0;
    if (s_fire) begin
      unique case (req)
        REQ_ALLOC: begin
          // oversize wins over empty; a failed allocate leaves the pool alone
          if (req_size > blk_bytes) begin
            res_status = STAT_OVERSIZE;
          end else if (free_blocks == '0 || head_index >= count_eff) begin
            res_status = STAT_EMPTY;
          end else begin
            res_index        = head_low;
            res_address      = base_address + {8'd0, offset};
            free_blocks_next = free_blocks - 1'b1;
            // follow the stored link, or bump to the next untouched block
            head_index_next  = head_valid ? {1'b0, head_link} : head_index + 1'b1;
          end
        end
        REQ_FREE: begin
          if ({1'b0, req_fidx} >= count_eff) begin
            res_status = STAT_RANGE;
          end else begin
            link_we         = 1'b1;
            free_ok         = 1'b1;
            head_index_next = {1'b0, req_fidx};
            // saturates under repeated double frees
            if (free_blocks != COUNT_MAX) begin
              free_blocks_next = free_blocks + 1'b1;
            end
          end
        end
        REQ_RESET: begin
          pool_clear       = 1'b1;
          head_index_next  = '0;
          free_blocks_next = count_eff;
        end
        REQ_NOP: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_index  <= '0;
      free_blocks <= COUNT_CAP;
      link_valid  <= '0;
      fwd_valid   <= 1'b0;
    end else begin
      head_index  <= head_index_next;
      free_blocks <= free_blocks_next;
      fwd_valid   <= free_ok;
      if (pool_clear) begin
        link_valid <= '0;
      end else if (link_we) begin
        link_valid[req_fidx] <= 1'b1;
      end
    end
  end

  // forwarded link is the old head, stored by the free
  always_ff @(posedge clk) begin
    if (free_ok) begin
      fwd_link <= head_low;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      out_status  <= res_status;
      out_index   <= res_index;
      out_address <= res_address;
      out_count   <= free_blocks_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {7'd0, out_count, out_address, out_index};

endmodule

@@ rtl/pfl_ram.sv @@
// pfl_ram: generic single-write, single-read ram with registered read data
// read during write to the same address returns the old contents
// no dependencies
module pfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/pfl_checker.sv @@
// pfl_checker: port-level assertions for pool_free_list_allocator
// depends on pfl_pkg; attached to the top level by the bind below
module pfl_checker
  import pfl_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [23:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        pready
);

  logic s_fire;
  assign s_fire = s_tvalid && s_tready;

  // every accepted item has its result on the next cycle
  a_result_next: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> m_tvalid)
    else $error("no result after accepted item");

  // failed requests carry no block
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != STAT_OK) |-> (m_tdata[39:0] == 40'd0))
    else $error("failed request returned a block");

  // out-of-range status only answers a free
  a_range_only_free: assert property (@(posedge clk) disable iff (rst)
    (s_fire && s_tuser != REQ_FREE) |=> (m_tuser != STAT_RANGE))
    else $error("range status on a request that is not a free");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind pool_free_list_allocator pfl_checker u_pfl_checker (.*);
